// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    // pool size default and fixed field widths
    localparam int POOL_SLOTS_DEF = 64;
    localparam int SLOT_W         = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int GTERM_W        = 42;

    // 0.005 as an unsigned Q0.32 value
    localparam logic [24:0] GRAV_SCALE_Q32 = 25'd21474836;
    // life of a free slot, -1.0 in Q16.16
    localparam logic signed [31:0] LIFE_FREE = -32'sd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIFE_INIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOUR = 3'd6;

    // command codes
    localparam logic CMD_SPAWN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    // one slot record apart from its life
    typedef struct packed {
        vec3_t       pos;
        vec3_t       vel;
        logic [15:0] size;
        logic [31:0] colour;
    } rec_t;

    // write-back of one stepped slot
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] life;
        rec_t               rec;
    } wb_t;

    // report of one live slot
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        vec3_t             pos;
        logic [15:0]       size;
        logic [31:0]       colour;
        logic [63:0]       sq_dist;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? 64'hffff_ffff_ffff_ffff : s[63:0];
    endfunction

endpackage

// ===== rtl/pps_life_mem.sv =====
module pps_life_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic signed [31:0]       rd_life,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic signed [31:0]       wr_life
);
    import pps_pkg::*;

    logic signed [31:0] mem [DEPTH];
    logic [DEPTH-1:0]   written_reg;
    logic signed [31:0] rd_q_reg;
    logic               rd_vld_reg;

    // per-slot written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= written_reg[rd_addr];
        end
    end

    // storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_life;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    // never-written slot reads as free
    assign rd_life = rd_vld_reg ? rd_q_reg : LIFE_FREE;

endmodule

// ===== rtl/pps_rec_mem.sv =====
module pps_rec_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output pps_pkg::rec_t            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pps_pkg::rec_t            wr_data
);
    import pps_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_q_reg;

    // storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    assign rd_data = rd_q_reg;

endmodule

// ===== rtl/pps_step_pipe.sv =====
module pps_step_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_en,
    input  logic [pps_pkg::SLOT_W-1:0]          in_slot,
    input  logic signed [31:0]                  in_life,
    input  pps_pkg::rec_t                       in_rec,
    input  logic [31:0]                         dt,
    input  logic signed [pps_pkg::GTERM_W-1:0]  gterm,
    input  pps_pkg::vec3_t                      cam,
    output logic                                wb_en,
    output pps_pkg::wb_t                        wb,
    output logic                                res_en,
    output pps_pkg::res_t                       res,
    output logic                                pipe_busy
);
    import pps_pkg::*;

    logic signed [32:0] dt_s;
    assign dt_s = signed'({1'b0, dt});

    // stage a: life and y velocity
    logic               a_en_reg;
    logic [SLOT_W-1:0]  a_slot_reg;
    logic signed [31:0] a_life_reg;
    rec_t               a_rec_reg;

    // stage b: velocity times delta
    logic               b_en_reg;
    logic [SLOT_W-1:0]  b_slot_reg;
    logic signed [31:0] b_life_reg;
    rec_t               b_rec_reg;
    logic signed [64:0] b_px_reg, b_py_reg, b_pz_reg;

    // stage c: new position, written back
    logic               c_en_reg;
    logic [SLOT_W-1:0]  c_slot_reg;
    logic signed [31:0] c_life_reg;
    rec_t               c_rec_reg;

    // stage d: distance magnitudes
    logic               d_en_reg;
    logic [SLOT_W-1:0]  d_slot_reg;
    rec_t               d_rec_reg;
    logic [31:0]        d_ax_reg, d_ay_reg, d_az_reg;

    // stage e: squares
    logic               e_en_reg;
    logic [SLOT_W-1:0]  e_slot_reg;
    rec_t               e_rec_reg;
    logic [63:0]        e_sx_reg, e_sy_reg, e_sz_reg;

    // stage f: summed report
    logic               f_en_reg;
    res_t               f_res_reg;

    logic               live;
    logic signed [31:0] life_n;
    rec_t               rec_a;
    vec3_t              pos_n;
    logic signed [32:0] dx, dy, dz;

    // position plus floored step
    function automatic logic signed [63:0] c_in_x(input logic signed [31:0] p,
                                                   input logic signed [64:0] prod);
        logic signed [64:0] sh;
        sh = prod >>> 16;
        return 64'(p) + 64'(sh);
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] m;
        m = v[32] ? -v : v;
        return m[31:0];
    endfunction

    always_comb
    begin
        live      = in_life > 32'sd0;
        life_n    = sat32(64'(in_life) - 64'(dt_s));
        rec_a     = in_rec;
        rec_a.vel.y = sat32(64'(in_rec.vel.y) + 64'(gterm));
        pos_n.x   = sat32(64'(c_in_x(b_rec_reg.pos.x, b_px_reg)));
        pos_n.y   = sat32(64'(c_in_x(b_rec_reg.pos.y, b_py_reg)));
        pos_n.z   = sat32(64'(c_in_x(b_rec_reg.pos.z, b_pz_reg)));
        dx        = 33'(c_rec_reg.pos.x) - 33'(cam.x);
        dy        = 33'(c_rec_reg.pos.y) - 33'(cam.y);
        dz        = 33'(c_rec_reg.pos.z) - 33'(cam.z);
    end

    // valid flags of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_en_reg <= 1'b0;
            b_en_reg <= 1'b0;
            c_en_reg <= 1'b0;
            d_en_reg <= 1'b0;
            e_en_reg <= 1'b0;
            f_en_reg <= 1'b0;
        end
        else
        begin
            a_en_reg <= in_en && live;
            b_en_reg <= a_en_reg;
            c_en_reg <= b_en_reg;
            d_en_reg <= c_en_reg;
            e_en_reg <= d_en_reg;
            f_en_reg <= e_en_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_slot_reg <= in_slot;
        a_life_reg <= life_n;
        a_rec_reg  <= rec_a;

        b_slot_reg <= a_slot_reg;
        b_life_reg <= a_life_reg;
        b_rec_reg  <= a_rec_reg;
        b_px_reg   <= 65'(a_rec_reg.vel.x) * 65'(dt_s);
        b_py_reg   <= 65'(a_rec_reg.vel.y) * 65'(dt_s);
        b_pz_reg   <= 65'(a_rec_reg.vel.z) * 65'(dt_s);

        c_slot_reg <= b_slot_reg;
        c_life_reg <= b_life_reg;
        c_rec_reg  <= '{pos: pos_n, vel: b_rec_reg.vel, size: b_rec_reg.size,
                        colour: b_rec_reg.colour};

        d_slot_reg <= c_slot_reg;
        d_rec_reg  <= c_rec_reg;
        d_ax_reg   <= mag33(dx);
        d_ay_reg   <= mag33(dy);
        d_az_reg   <= mag33(dz);

        e_slot_reg <= d_slot_reg;
        e_rec_reg  <= d_rec_reg;
        e_sx_reg   <= {32'd0, d_ax_reg} * {32'd0, d_ax_reg};
        e_sy_reg   <= {32'd0, d_ay_reg} * {32'd0, d_ay_reg};
        e_sz_reg   <= {32'd0, d_az_reg} * {32'd0, d_az_reg};

        f_res_reg.slot    <= e_slot_reg;
        f_res_reg.pos     <= e_rec_reg.pos;
        f_res_reg.size    <= e_rec_reg.size;
        f_res_reg.colour  <= e_rec_reg.colour;
        f_res_reg.sq_dist <= sat_add64(sat_add64(e_sx_reg, e_sy_reg), e_sz_reg);
    end

    // write-back after the position update
    assign wb_en   = c_en_reg;
    assign wb.slot = c_slot_reg;
    assign wb.life = c_life_reg;
    assign wb.rec  = c_rec_reg;

    assign res_en    = f_en_reg;
    assign res       = f_res_reg;
    assign pipe_busy = a_en_reg | b_en_reg | c_en_reg | d_en_reg | e_en_reg | f_en_reg;

endmodule

// ===== rtl/particle_pool_step.sv =====
// particle pool: spawn and step commands over a pool of POOL_SLOTS particles
//
// command channel: an item transfers on a rising edge with start high and busy
// low. command selects spawn (searches a free slot and loads it) or step
// (ages and moves every live slot). Registers are to be written over cfg_wr_en,
// cfg_index, cfg_data by the user only while busy is low; the block does not
// enforce this. An unknown index is ignored.
// result channel: out_strobe marks each result for one cycle; out_last marks
// the final result of a command. Results cannot be held off by the receiver.
// spawn: the search reads one slot life per cycle from the life memory over 1 to
// POOL_SLOTS slots; the result shows in the same cycle that busy drops.
// step: states ST_DT, ST_GDT and ST_GT form the scaled delta and gravity term,
// then one slot per cycle is read from the memories and sent through a 6-stage
// update pipeline that writes back as it goes; the final result shows in the
// same cycle that busy drops. Results of a step come in slot order, one per
// live slot, or one result with out_valid low when no slot is live.
// reset: all slots free, search start at slot 0, registers at defaults; no
// clearing pass is needed since slot life carries per-slot written flags.
module particle_pool_step #(
    parameter int POOL_SLOTS = pps_pkg::POOL_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [23:0]                      delta_time,
    input  logic signed [31:0]               spawn_x,
    input  logic signed [31:0]               spawn_y,
    input  logic signed [31:0]               spawn_z,
    input  logic [15:0]                      spawn_size,
    input  logic signed [31:0]               cam_x,
    input  logic signed [31:0]               cam_y,
    input  logic signed [31:0]               cam_z,
    input  logic                             cfg_wr_en,
    input  logic [pps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_strobe,
    output logic [5:0]                       out_slot,
    output logic                             out_valid,
    output logic signed [31:0]               out_pos_x,
    output logic signed [31:0]               out_pos_y,
    output logic signed [31:0]               out_pos_z,
    output logic [15:0]                      out_size,
    output logic [31:0]                      out_colour,
    output logic [63:0]                      out_distance,
    output logic                             out_last
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DT, ST_GDT, ST_GT, ST_RUN, ST_DRAIN, ST_FLUSH, ST_SRCH, ST_SPAWN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [30:0]        life_init_reg;
    logic signed [31:0] gravity_reg;
    logic [23:0]        time_scale_reg;
    vec3_t              dir_reg;
    logic [31:0]        start_colour_reg;

    // latched command fields
    logic [23:0]        dtime_reg;
    vec3_t              spos_reg;
    logic [15:0]        ssize_reg;
    vec3_t              cam_reg;

    // step factors
    logic [31:0]                dt_reg;
    logic [24:0]                gdt_reg;
    logic signed [GTERM_W-1:0]  gterm_reg;

    // slot walk
    logic [IDX_W-1:0]   search_start_reg;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [CNT_W-1:0]   chk_cnt_reg;
    logic               chk_valid_reg;
    logic [IDX_W-1:0]   chk_addr_reg;
    logic [IDX_W-1:0]   slot_sel_reg;

    // held report, so the final one can carry out_last
    logic               held_valid_reg;
    res_t               held_reg;

    // result registers
    logic               out_strobe_reg;
    res_t               out_res_reg;
    logic               out_valid_reg;
    logic               out_last_reg;

    // memory ports
    logic               rd_en;
    logic signed [31:0] rd_life;
    rec_t               rd_rec;
    logic               life_we;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] life_wdata;
    rec_t               rec_wdata;
    rec_t               spawn_rec;

    // pipeline
    logic               pipe_in_en;
    logic               wb_en;
    wb_t                wb;
    logic               res_en;
    res_t               res;
    logic               pipe_busy;

    logic               accept;
    logic               step_mode;
    logic [IDX_W-1:0]   scan_addr_inc;
    logic [47:0]        dt_prod;
    logic [56:0]        gdt_prod;
    logic signed [57:0] gt_prod;
    logic signed [57:0] gt_shift;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = state_reg != ST_IDLE;
    assign step_mode = (state_reg == ST_RUN) || (state_reg == ST_DRAIN);

    // memory read and write control
    always_comb
    begin
        rd_en = (state_reg == ST_RUN)
             || ((state_reg == ST_SRCH) && (scan_cnt_reg < CNT_W'(POOL_SLOTS)));
        spawn_rec.pos    = spos_reg;
        spawn_rec.vel    = dir_reg;
        spawn_rec.size   = ssize_reg;
        spawn_rec.colour = start_colour_reg;
        if (state_reg == ST_SPAWN)
        begin
            life_we    = 1'b1;
            wr_addr    = slot_sel_reg;
            life_wdata = signed'({1'b0, life_init_reg});
            rec_wdata  = spawn_rec;
        end
        else
        begin
            life_we    = wb_en;
            wr_addr    = wb.slot[IDX_W-1:0];
            life_wdata = wb.life;
            rec_wdata  = wb.rec;
        end
        scan_addr_inc = (scan_addr_reg == IDX_W'(POOL_SLOTS - 1)) ? '0 : scan_addr_reg + 1'b1;
        pipe_in_en    = chk_valid_reg && step_mode;
        dt_prod       = 48'(dtime_reg) * 48'(time_scale_reg);
        gdt_prod      = 57'(dt_reg) * 57'(GRAV_SCALE_Q32);
        gt_prod       = 58'(gravity_reg) * 58'(signed'({1'b0, gdt_reg}));
        gt_shift      = gt_prod >>> 16;
    end

    pps_life_mem #(.DEPTH(POOL_SLOTS)) u_life_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_life (rd_life),
        .wr_en   (life_we),
        .wr_addr (wr_addr),
        .wr_life (life_wdata)
    );

    pps_rec_mem #(.DEPTH(POOL_SLOTS)) u_rec_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_rec),
        .wr_en   (life_we),
        .wr_addr (wr_addr),
        .wr_data (rec_wdata)
    );

    pps_step_pipe u_step_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_en     (pipe_in_en),
        .in_slot   (SLOT_W'(chk_addr_reg)),
        .in_life   (rd_life),
        .in_rec    (rd_rec),
        .dt        (dt_reg),
        .gterm     (gterm_reg),
        .cam       (cam_reg),
        .wb_en     (wb_en),
        .wb        (wb),
        .res_en    (res_en),
        .res       (res),
        .pipe_busy (pipe_busy)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_init_reg    <= 31'd1638400;
            gravity_reg      <= '0;
            time_scale_reg   <= 24'd65536;
            dir_reg          <= '0;
            start_colour_reg <= 32'hffff_ffff;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LIFE_INIT:    life_init_reg    <= cfg_data[30:0];
                REG_GRAVITY:      gravity_reg      <= signed'(cfg_data);
                REG_TIME_SCALE:   time_scale_reg   <= cfg_data[23:0];
                REG_DIR_X:        dir_reg.x        <= signed'(cfg_data);
                REG_DIR_Y:        dir_reg.y        <= signed'(cfg_data);
                REG_DIR_Z:        dir_reg.z        <= signed'(cfg_data);
                REG_START_COLOUR: start_colour_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // command fields and step factors
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dtime_reg <= delta_time;
            spos_reg  <= '{x: spawn_x, y: spawn_y, z: spawn_z};
            ssize_reg <= spawn_size;
            cam_reg   <= '{x: cam_x, y: cam_y, z: cam_z};
        end
        if (state_reg == ST_DT)
            dt_reg <= dt_prod[47:16];
        if (state_reg == ST_GDT)
            gdt_reg <= gdt_prod[56:32];
        if (state_reg == ST_GT)
            gterm_reg <= GTERM_W'(gt_shift);
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            search_start_reg <= '0;
            scan_addr_reg    <= '0;
            scan_cnt_reg     <= '0;
            chk_cnt_reg      <= '0;
            chk_valid_reg    <= 1'b0;
            chk_addr_reg     <= '0;
            slot_sel_reg     <= '0;
            held_valid_reg   <= 1'b0;
            held_reg         <= '0;
            out_strobe_reg   <= 1'b0;
            out_res_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            out_strobe_reg <= 1'b0;
            chk_valid_reg  <= rd_en;
            chk_addr_reg   <= scan_addr_reg;

            // a new live report pushes out the one held before it
            if (res_en)
            begin
                if (held_valid_reg)
                begin
                    out_strobe_reg <= 1'b1;
                    out_res_reg    <= held_reg;
                    out_valid_reg  <= 1'b1;
                    out_last_reg   <= 1'b0;
                end
                held_reg       <= res;
                held_valid_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        scan_cnt_reg <= '0;
                        chk_cnt_reg  <= '0;
                        if (command == CMD_SPAWN)
                        begin
                            scan_addr_reg <= search_start_reg;
                            state_reg     <= ST_SRCH;
                        end
                        else
                        begin
                            state_reg <= ST_DT;
                        end
                    end
                end
                ST_DT:
                begin
                    state_reg <= ST_GDT;
                end
                ST_GDT:
                begin
                    state_reg <= ST_GT;
                end
                ST_GT:
                begin
                    scan_addr_reg  <= '0;
                    scan_cnt_reg   <= '0;
                    held_valid_reg <= 1'b0;
                    state_reg      <= ST_RUN;
                end
                ST_RUN:
                begin
                    scan_addr_reg <= scan_addr_inc;
                    scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == CNT_W'(POOL_SLOTS - 1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (!chk_valid_reg && !pipe_busy)
                        state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    out_strobe_reg <= 1'b1;
                    out_last_reg   <= 1'b1;
                    out_valid_reg  <= held_valid_reg;
                    out_res_reg    <= held_valid_reg ? held_reg : '0;
                    held_valid_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                ST_SRCH:
                begin
                    if (rd_en)
                    begin
                        scan_addr_reg <= scan_addr_inc;
                        scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    end
                    if (chk_valid_reg)
                    begin
                        chk_cnt_reg <= chk_cnt_reg + 1'b1;
                        // free slot found, or pool full falls back to slot 0
                        priority if (rd_life < 32'sd0)
                        begin
                            slot_sel_reg     <= chk_addr_reg;
                            search_start_reg <= chk_addr_reg;
                            state_reg        <= ST_SPAWN;
                        end
                        else if (chk_cnt_reg == CNT_W'(POOL_SLOTS - 1))
                        begin
                            slot_sel_reg <= '0;
                            state_reg    <= ST_SPAWN;
                        end
                    end
                end
                ST_SPAWN:
                begin
                    out_strobe_reg      <= 1'b1;
                    out_valid_reg       <= 1'b1;
                    out_last_reg        <= 1'b1;
                    out_res_reg.slot    <= SLOT_W'(slot_sel_reg);
                    out_res_reg.pos     <= spos_reg;
                    out_res_reg.size    <= ssize_reg;
                    out_res_reg.colour  <= start_colour_reg;
                    out_res_reg.sq_dist <= '0;
                    state_reg           <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_strobe   = out_strobe_reg;
    assign out_slot     = out_res_reg.slot;
    assign out_valid    = out_valid_reg;
    assign out_pos_x    = out_res_reg.pos.x;
    assign out_pos_y    = out_res_reg.pos.y;
    assign out_pos_z    = out_res_reg.pos.z;
    assign out_size     = out_res_reg.size;
    assign out_colour   = out_res_reg.colour;
    assign out_distance = out_res_reg.sq_dist;
    assign out_last     = out_last_reg;

endmodule

// ===== rtl/pps_checker.sv =====
module pps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        out_strobe,
    input logic        out_valid,
    input logic        out_last,
    input logic [63:0] out_distance
);

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // an empty step report is always final and carries no distance
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && !out_valid |-> out_last && (out_distance == 64'd0))
        else $error("empty report not final or has distance");

    // the final result of a command is shown once the block is idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && out_last |-> !busy)
        else $error("final result while still busy");

    // nothing follows the final result in the next cycle
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && out_last |=> !out_strobe)
        else $error("result after final transfer");

endmodule

bind particle_pool_step pps_checker u_pps_checker (.*);
